[hw/rtl/ascii_to_uint64_parser_macros.svh]
// ----------------------------------------------------------------------------
// ASCII to uint64 parser assertion macros
// Shared concurrent assertion forms used by the parser checker.
// ----------------------------------------------------------------------------
`ifndef ASCII_TO_UINT64_PARSER_MACROS_SVH
`define ASCII_TO_UINT64_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define A2U_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a2u assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define A2U_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("a2u assertion failed (next cycle)");

`endif

[hw/rtl/a2u_pkg.sv]
// ----------------------------------------------------------------------------
// ASCII to uint64 parser package
// Types, character codes, status codes and helpers shared by the parser.
// ----------------------------------------------------------------------------
package a2u_pkg;

    localparam int CH_W    = 8;
    localparam int VALUE_W = 64;
    localparam int BASE_W  = 6;
    localparam int POS_W   = 13;
    localparam int PROD_W  = VALUE_W + BASE_W;

    localparam int MAX_LEN_DEF = 4096;
    localparam int POS_HW_CAP  = (1 << POS_W) - 1;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] CASE_OFS = 8'd32;
    localparam logic [CH_W-1:0] ALPHA_OFS = 8'd10;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_W-1:0] NO_DIGIT  = 6'd63;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_NODIG = 2'd1,
        STATUS_OVF   = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_SKIP   = 5'b00001,
        PH_ZERO   = 5'b00010,
        PH_DIGITS = 5'b00100,
        PH_OVER   = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] accum;
        phase_t             phase;
        logic [BASE_W-1:0]  base_now;
        logic               digit_seen;
        logic [POS_W-1:0]   position;
    } parse_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
        logic [POS_W-1:0]   end_index;
    } parse_result_t;

    function automatic parse_state_t state_clear();
        parse_state_t s;
        s.accum      = '0;
        s.phase      = PH_SKIP;
        s.base_now   = BASE_AUTO;
        s.digit_seen = 1'b0;
        s.position   = '0;
        return s;
    endfunction

    // Maps 0-9, a-z and A-Z to 0..35; anything else gives NO_DIGIT.
    function automatic logic [BASE_W-1:0] digit_value(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] lc;
        lc = c;
        if (c >= CH_UA && c <= CH_UZ) begin
            lc = c + CASE_OFS;
        end
        if (lc >= CH_ZERO && lc <= CH_NINE) begin
            return BASE_W'(lc - CH_ZERO);
        end else if (lc >= CH_LA && lc <= CH_LZ) begin
            return BASE_W'(lc - CH_LA + ALPHA_OFS);
        end
        return NO_DIGIT;
    endfunction

endpackage

[hw/rtl/a2u_step.sv]
// ----------------------------------------------------------------------------
// ASCII to uint64 parser step logic
// Next-state and result logic for one character of the string.
// ----------------------------------------------------------------------------
module a2u_step #(
    parameter int MAX_LEN = a2u_pkg::MAX_LEN_DEF
) (
    input  a2u_pkg::parse_state_t             cur,
    input  logic [a2u_pkg::CH_W-1:0]          ch,
    input  logic [a2u_pkg::BASE_W-1:0]        base_choice,
    output a2u_pkg::parse_state_t             nxt,
    output logic                              emit,
    output a2u_pkg::parse_result_t            res
);
    import a2u_pkg::*;

    localparam int PosCapInt = (MAX_LEN < POS_HW_CAP) ? MAX_LEN : POS_HW_CAP;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(PosCapInt);

    parse_state_t       pre;
    logic               go_digits;
    logic               is_space;
    logic [BASE_W-1:0]  bsel;
    logic [BASE_W-1:0]  b_eff;
    logic [BASE_W-1:0]  dval;
    logic [PROD_W-1:0]  prod;
    logic [POS_W-1:0]   pos_inc;

    assign is_space = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
    assign bsel     = (base_choice > BASE_MAX) ? BASE_MAX : base_choice;
    assign pos_inc  = (cur.position < POS_CAP) ? cur.position + 1'b1 : cur.position;
    assign dval     = digit_value(ch);

    // First pass: handle whitespace, prefix and base selection, and set up the
    // state that the digit-or-stop stage works on.
    always_comb begin
        pre       = cur;
        nxt       = cur;
        go_digits = 1'b0;
        emit      = 1'b0;
        unique case (cur.phase)
            PH_SKIP: begin
                if (is_space) begin
                    nxt.position = pos_inc;
                end else if (ch == CH_NUL) begin
                    emit = 1'b1;
                    nxt  = state_clear();
                end else if (ch == CH_ZERO && (bsel == BASE_AUTO || bsel == BASE_HEX)) begin
                    nxt.base_now = bsel;
                    nxt.phase    = PH_ZERO;
                    nxt.position = pos_inc;
                end else begin
                    pre.base_now = (bsel == BASE_AUTO) ? BASE_DEC : bsel;
                    pre.phase    = PH_DIGITS;
                    go_digits    = 1'b1;
                end
            end
            PH_ZERO: begin
                if (ch == CH_LX) begin
                    nxt.base_now = BASE_HEX;
                    nxt.phase    = PH_DIGITS;
                    nxt.position = pos_inc;
                end else begin
                    if (cur.base_now == BASE_AUTO) begin
                        pre.base_now = (ch >= CH_ZERO && ch <= CH_SEVEN) ? BASE_OCT : BASE_DEC;
                    end
                    pre.phase      = PH_DIGITS;
                    pre.digit_seen = 1'b1;
                    pre.accum      = '0;
                    go_digits      = 1'b1;
                end
            end
            PH_DIGITS, PH_OVER: begin
                go_digits = 1'b1;
            end
            PH_DONE: begin
                if (ch == CH_NUL) begin
                    nxt = state_clear();
                end
            end
            default: begin
                nxt = state_clear();
            end
        endcase

        b_eff = (pre.base_now == BASE_AUTO) ? BASE_DEC : pre.base_now;
        prod  = PROD_W'(pre.accum) * PROD_W'(b_eff) + PROD_W'(dval);

        if (go_digits) begin
            nxt = pre;
            if (ch != CH_NUL && dval < b_eff) begin
                nxt.digit_seen = 1'b1;
                if (pre.phase != PH_OVER) begin
                    // Any bit above the low 64 means the value no longer fits.
                    if (prod[PROD_W-1:VALUE_W] != '0) begin
                        nxt.accum = '1;
                        nxt.phase = PH_OVER;
                    end else begin
                        nxt.accum = prod[VALUE_W-1:0];
                    end
                end
                nxt.position = pos_inc;
            end else begin
                emit = 1'b1;
                if (ch == CH_NUL) begin
                    nxt = state_clear();
                end else begin
                    nxt.phase = PH_DONE;
                end
            end
        end

        res.end_index = pre.position;
        if (!pre.digit_seen) begin
            res.value  = '0;
            res.status = STATUS_NODIG;
        end else if (pre.phase == PH_OVER) begin
            res.value  = '1;
            res.status = STATUS_OVF;
        end else begin
            res.value  = pre.accum;
            res.status = STATUS_OK;
        end
    end

endmodule

[hw/rtl/ascii_to_uint64_parser.sv]
// ----------------------------------------------------------------------------
// ASCII to uint64 parser
// strtoull-style conversion of a NUL-terminated character stream.
// ----------------------------------------------------------------------------
// The parser takes one character per clock cycle while s_ready is high and gives
// at most one result per string: value, status and the count of characters
// consumed before the stopping character. Every character, including the one
// that produces a result, is absorbed by a combinational state update (a 64 x
// 6 bit multiply, an add and a carry check on the accumulator) into the state
// register. Results sit in an output register, so s_ready drops only while a
// result is waiting there and m_ready is low. The base register is sampled at
// the first non-whitespace character of each string; write it only while the
// parser is idle.
module ascii_to_uint64_parser #(
    parameter int MAX_LEN = a2u_pkg::MAX_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [a2u_pkg::BASE_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [a2u_pkg::CH_W-1:0]      s_ch,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [a2u_pkg::VALUE_W-1:0]   m_value,
    output logic [1:0]                    m_status,
    output logic [a2u_pkg::POS_W-1:0]     m_end_index
);
    import a2u_pkg::*;

    parse_state_t       state_reg;
    parse_state_t       state_next;
    parse_state_t       step_state;
    parse_result_t      step_res;
    parse_result_t      result_reg;
    logic               step_emit;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [BASE_W-1:0]  base_choice_reg;
    logic               accept;

    a2u_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .cur         (state_reg),
        .ch          (s_ch),
        .base_choice (base_choice_reg),
        .nxt         (step_state),
        .emit        (step_emit),
        .res         (step_res)
    );

    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign state_next = accept ? step_state : state_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept && step_emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= state_clear();
            m_valid_reg     <= 1'b0;
            base_choice_reg <= BASE_AUTO;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                base_choice_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && step_emit) begin
            result_reg <= step_res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = result_reg.value;
    assign m_status    = result_reg.status;
    assign m_end_index = result_reg.end_index;

endmodule

[hw/rtl/a2u_checker.sv]
// ----------------------------------------------------------------------------
// ASCII to uint64 parser checker
// Port-level assertions on the result channel and on s_ready, bound to the top level.
// ----------------------------------------------------------------------------
`include "ascii_to_uint64_parser_macros.svh"

module a2u_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [a2u_pkg::VALUE_W-1:0]   m_value,
    input logic [1:0]                    m_status
);
    import a2u_pkg::*;

    // A status code outside the three defined ones means a corrupted result.
    `A2U_ASSERT_SAME(a_status_legal, aclk, aresetn, m_valid, m_status != 2'd3)

    `A2U_ASSERT_SAME(a_ovf_all_ones, aclk, aresetn, m_valid && m_status == STATUS_OVF, m_value == '1)

    `A2U_ASSERT_SAME(a_nodig_zero, aclk, aresetn, m_valid && m_status == STATUS_NODIG, m_value == '0)

    // With no result pending the parser must take a new character.
    `A2U_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    `A2U_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value) && $stable(m_status))

endmodule

bind ascii_to_uint64_parser a2u_checker u_a2u_checker (.*);

[sim/ascii_to_uint64_parser_tb.sv]
// ----------------------------------------------------------------------------
// ASCII to uint64 parser testbench
// Streams character strings into the parser under several base settings and
// checks every result against a cycle-free model of the parse kept in the
// bench, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module ascii_to_uint64_parser_tb;
    import a2u_pkg::*;

    // Saturation point of end_index at the default MAX_LEN.
    localparam int POS_CAP      = 4096;
    localparam int QUIET_LIMIT  = 500;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_CHARS  = 100;
    localparam int N_PHASES     = 11;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [BASE_W-1:0]    cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [CH_W-1:0]      s_ch        = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [VALUE_W-1:0]   m_value;
    logic [1:0]           m_status;
    logic [POS_W-1:0]     m_end_index;

    // Bench copy of the parse state and the base register.
    logic [VALUE_W-1:0]   acc;
    phase_t               ph;
    logic [BASE_W-1:0]    bnow;
    logic                 seen;
    logic [POS_W-1:0]     pos;
    logic [BASE_W-1:0]    base_cfg;

    logic [CH_W-1:0]      char_q[$];
    parse_result_t        result_q[$];

    int base_plan[N_PHASES] = '{0, 10, 16, 2, 8, 1, 36, 37, 63, 0, 0};
    int idle_max     = 5;
    int n_pushed     = 0;
    int n_chars      = 0;
    int n_results    = 0;
    int n_ovf        = 0;
    int n_nodig      = 0;
    int bad_count    = 0;
    int s_gap        = 0;
    int m_hold       = 0;
    int quiet_cycles = 0;

    ascii_to_uint64_parser i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_status    (m_status),
        .m_end_index (m_end_index)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Parse model
    // ------------------------------------------------------------------
    function automatic logic [BASE_W-1:0] char_weight(input logic [CH_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return BASE_W'(c - CH_ZERO);
        end
        if (c >= CH_UA && c <= CH_UZ) begin
            return BASE_W'(c - CH_UA) + BASE_DEC;
        end
        if (c >= CH_LA && c <= CH_LZ) begin
            return BASE_W'(c - CH_LA) + BASE_DEC;
        end
        return NO_DIGIT;
    endfunction

    function automatic void bump_pos();
        if (pos < POS_CAP) begin
            pos = pos + 1'b1;
        end
    endfunction

    function automatic void clear_scan();
        acc  = '0;
        ph   = PH_SKIP;
        bnow = BASE_AUTO;
        seen = 1'b0;
        pos  = '0;
    endfunction

    function automatic parse_result_t scan_report();
        parse_result_t r;
        r.end_index = pos;
        if (!seen) begin
            r.value  = '0;
            r.status = STATUS_NODIG;
        end else if (ph == PH_OVER) begin
            r.value  = '1;
            r.status = STATUS_OVF;
        end else begin
            r.value  = acc;
            r.status = STATUS_OK;
        end
        return r;
    endfunction

    // Accumulates one digit, or stops the number and reports it.
    function automatic bit take_digit(input logic [CH_W-1:0] c, output parse_result_t r);
        logic [BASE_W-1:0] d;
        logic [PROD_W-1:0] prod;
        d = char_weight(c);
        r = '0;
        if (c != CH_NUL && d < bnow) begin
            seen = 1'b1;
            if (ph != PH_OVER) begin
                prod = PROD_W'(acc) * PROD_W'(bnow) + PROD_W'(d);
                if (prod[PROD_W-1:VALUE_W] != '0) begin
                    acc = '1;
                    ph  = PH_OVER;
                end else begin
                    acc = prod[VALUE_W-1:0];
                end
            end
            bump_pos();
            return 1'b0;
        end
        r = scan_report();
        if (c == CH_NUL) begin
            clear_scan();
        end else begin
            ph = PH_DONE;
        end
        return 1'b1;
    endfunction

    function automatic bit scan_char(input logic [CH_W-1:0] c, output parse_result_t r);
        logic [BASE_W-1:0] b;
        r = '0;
        case (ph)
            PH_SKIP: begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
                    bump_pos();
                    return 1'b0;
                end
                if (c == CH_NUL) begin
                    r = scan_report();
                    clear_scan();
                    return 1'b1;
                end
                // The base is latched here, at the first visible character.
                b = (base_cfg > BASE_MAX) ? BASE_MAX : base_cfg;
                bnow = b;
                if (c == CH_ZERO && (b == BASE_AUTO || b == BASE_HEX)) begin
                    ph = PH_ZERO;
                    bump_pos();
                    return 1'b0;
                end
                if (b == BASE_AUTO) begin
                    bnow = BASE_DEC;
                end
                ph = PH_DIGITS;
                return take_digit(c, r);
            end
            PH_ZERO: begin
                if (c == CH_LX) begin
                    bnow = BASE_HEX;
                    ph   = PH_DIGITS;
                    bump_pos();
                    return 1'b0;
                end
                if (bnow == BASE_AUTO) begin
                    bnow = (c >= CH_ZERO && c <= CH_SEVEN) ? BASE_OCT : BASE_DEC;
                end
                ph   = PH_DIGITS;
                seen = 1'b1;
                acc  = '0;
                return take_digit(c, r);
            end
            PH_DIGITS, PH_OVER: begin
                return take_digit(c, r);
            end
            default: begin
                if (c == CH_NUL) begin
                    clear_scan();
                end
            end
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_char(input logic [CH_W-1:0] c);
        char_q.push_back(c);
        n_pushed++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i]);
        end
    endfunction

    function automatic logic [CH_W-1:0] pick_ws();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] digit_char(input int d);
        if (d < 10) begin
            return CH_ZERO + CH_W'(d);
        end
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + CH_W'(d - 10);
    endfunction

    // One string, mostly a well-formed number for the given base setting.
    function automatic void gen_string(input int base_sel);
        int eff;
        int ndig;
        eff = (base_sel > 36) ? 36 : base_sel;
        case ($urandom_range(0, 9))
            7: begin
                repeat ($urandom_range(0, 3)) push_char(pick_ws());
                push_char(CH_NUL);
            end
            8, 9: begin
                repeat ($urandom_range(1, 8)) push_char(CH_W'($urandom_range(0, 255)));
                push_char(CH_NUL);
            end
            default: begin
                repeat ($urandom_range(0, 2)) push_char(pick_ws());
                if (eff == 0 || eff == 16) begin
                    case ($urandom_range(0, 9))
                        0: push_text("0X");
                        1, 2, 3, 4: begin
                            push_text("0x");
                            eff = 16;
                        end
                        5, 6: if (eff == 0) begin
                            push_char(CH_ZERO);
                            eff = 8;
                        end
                        default: ;
                    endcase
                end
                if (eff == 0) begin
                    eff = 10;
                end
                ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 70)
                                                   : $urandom_range(1, 8);
                repeat (ndig) push_char(digit_char($urandom_range(0, eff - 1)));
                if ($urandom_range(0, 1)) begin
                    push_char(CH_W'($urandom_range(1, 255)));
                    repeat ($urandom_range(0, 3)) push_char(CH_W'($urandom_range(1, 255)));
                end
                push_char(CH_NUL);
            end
        endcase
    endfunction

    task automatic write_base(input logic [BASE_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        base_cfg     = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic wait_drained(input int extra);
        while (n_chars != n_pushed || result_q.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic flag_bad(input string msg);
        bad_count++;
        if (bad_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int start;
        clear_scan();
        base_cfg = BASE_AUTO;
        base_plan[9] = $urandom_range(3, 35);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed strings under the reset base (auto-detect).
        push_text(" \t\r\n0x1F");
        push_char(CH_NUL);
        push_text("017");
        push_char(CH_NUL);
        push_text("0X");
        push_char(CH_NUL);
        push_text("0xg");
        push_char(CH_NUL);
        push_char(CH_NUL);
        push_text("9z!");
        push_char(CH_NUL);
        wait_drained(SETTLE_CYCLES);

        for (int p = 0; p < N_PHASES; p++) begin
            write_base(BASE_W'(base_plan[p]));
            idle_max = (p % 4 == 3) ? 0 : 5;
            start = n_pushed;
            if (base_plan[p] == 10) begin
                push_text("18446744073709551615");
                push_char(CH_NUL);
                push_text("18446744073709551616");
                push_char(CH_NUL);
                start = n_pushed;
            end
            if (base_plan[p] == 16) begin
                push_text("0xFFFFFFFFFFFFFFFF");
                push_char(CH_NUL);
                push_text("10000000000000000");
                push_char(CH_NUL);
            end
            while (n_pushed - start < PHASE_CHARS) gen_string(base_plan[p]);
            // Sometimes leave a string open so the next base write lands mid-string.
            if ($urandom_range(0, 1)) begin
                push_char(pick_ws());
                if ($urandom_range(0, 1)) begin
                    push_char(digit_char(1));
                end
            end
            wait_drained(SETTLE_CYCLES);
        end

        wait_drained(DRAIN_CYCLES);
        $display("Sent %0d characters across %0d base settings; checked %0d results",
                 n_chars, N_PHASES, n_results);
        $display("of which %0d overflowed and %0d had no digits.", n_ovf, n_nodig);
        if (bad_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Character driver: predicts each transaction as it is accepted.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_chars
        parse_result_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (scan_char(s_ch, r)) begin
                    result_q.push_back(r);
                    if (r.status == STATUS_OVF) n_ovf++;
                    if (r.status == STATUS_NODIG) n_nodig++;
                end
                n_chars++;
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (char_q.size() > 0) begin
                    s_ch    <= char_q.pop_front();
                    s_valid <= 1'b1;
                    s_gap = $urandom_range(0, idle_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        parse_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (result_q.size() == 0) begin
                    flag_bad($sformatf("unexpected result value=%h status=%0d end=%0d",
                                       m_value, m_status, m_end_index));
                end else begin
                    want = result_q.pop_front();
                    if (m_value !== want.value) begin
                        flag_bad($sformatf("result %0d value exp %h got %h",
                                           n_results, want.value, m_value));
                    end
                    if (m_status !== 2'(want.status)) begin
                        flag_bad($sformatf("result %0d status exp %0d got %0d",
                                           n_results, want.status, m_status));
                    end
                    if (m_end_index !== want.end_index) begin
                        flag_bad($sformatf("result %0d end_index exp %0d got %0d",
                                           n_results, want.end_index, m_end_index));
                    end
                end
                m_hold = $urandom_range(0, idle_max);
            end else if (m_valid && m_hold > 0) begin
                m_hold--;
            end
            m_ready <= (m_hold == 0);
        end
    end

    // Ends the run if neither channel moves a transaction for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
